### rtl/ipr_pkg.sv
// ipr_pkg: shared types and constants for the input event packet ring
// no dependencies; used by every module of the block, not by its two interfaces

package ipr_pkg;

	// configuration port geometry
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SYNC_TYPE    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_REPORT_CODE  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DROPPED_CODE = 2'd2;

	// reset values of the registers
	localparam logic [15:0] SYNC_TYPE_RST    = 16'd0;
	localparam logic [15:0] REPORT_CODE_RST  = 16'd0;
	localparam logic [15:0] DROPPED_CODE_RST = 16'd3;

	// request operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// one stored event
	typedef struct packed {
		logic [15:0]        ev_type;
		logic [15:0]        ev_code;
		logic signed [31:0] ev_value;
	} entry_t;

	// configuration values seen by the datapath
	typedef struct packed {
		logic [15:0] sync_type;
		logic [15:0] report_code;
		logic [15:0] dropped_code;
	} cfg_t;

	// per request status from the pointer control to the result stage
	typedef struct packed {
		logic   got_event;
		logic   overflowed;
		logic   marker_hit;
		entry_t marker;
	} ctrl_res_t;

endpackage

### rtl/ipr_req_if.sv
// ipr_req_if: request channel of the event ring (push or pop)
// depends on nothing

interface ipr_req_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [15:0]        event_type;
	logic [15:0]        event_code;
	logic signed [31:0] event_value;

	modport source (output valid, operation, event_type, event_code, event_value,
		input ready);
	modport sink (input valid, operation, event_type, event_code, event_value,
		output ready);
endinterface

### rtl/ipr_rsp_if.sv
// ipr_rsp_if: result channel of the event ring
// depends on nothing

interface ipr_rsp_if;
	logic               valid;
	logic               ready;
	logic               got_event;
	logic [15:0]        out_type;
	logic [15:0]        out_code;
	logic signed [31:0] out_value;
	logic               overflowed;

	modport source (output valid, got_event, out_type, out_code, out_value, overflowed,
		input ready);
	modport sink (input valid, got_event, out_type, out_code, out_value, overflowed,
		output ready);
endinterface

### rtl/ipr_cfg_regs.sv
// ipr_cfg_regs: APB-style configuration registers of the event ring
// depends on ipr_pkg

module ipr_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ipr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [ipr_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [ipr_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output ipr_pkg::cfg_t                    cfg
);

	logic [ipr_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;
	ipr_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[ipr_pkg::CFG_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_type    <= ipr_pkg::SYNC_TYPE_RST;
			cfg_q.report_code  <= ipr_pkg::REPORT_CODE_RST;
			cfg_q.dropped_code <= ipr_pkg::DROPPED_CODE_RST;
		end else if (wr_en) begin
			case (idx)
				ipr_pkg::REG_SYNC_TYPE:    cfg_q.sync_type    <= pwdata[15:0];
				ipr_pkg::REG_REPORT_CODE:  cfg_q.report_code  <= pwdata[15:0];
				ipr_pkg::REG_DROPPED_CODE: cfg_q.dropped_code <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			ipr_pkg::REG_SYNC_TYPE:    prdata = {16'd0, cfg_q.sync_type};
			ipr_pkg::REG_REPORT_CODE:  prdata = {16'd0, cfg_q.report_code};
			ipr_pkg::REG_DROPPED_CODE: prdata = {16'd0, cfg_q.dropped_code};
			default:                   prdata = '0;
		endcase
	end

endmodule

### rtl/ipr_store.sv
// ipr_store: event memory with one write port and one registered read port
// depends on ipr_pkg

module ipr_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ipr_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output ipr_pkg::entry_t rdata
);

	ipr_pkg::entry_t mem [DEPTH];
	ipr_pkg::entry_t rdata_q;

	assign rdata = rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

### rtl/ipr_ctrl.sv
// ipr_ctrl: write, read and commit pointers plus the overflow marker slot
// depends on ipr_pkg

module ipr_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  operation,
	input  ipr_pkg::entry_t       ev,
	input  ipr_pkg::cfg_t         cfg,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output ipr_pkg::entry_t       wdata,
	output logic [AW-1:0]         raddr,
	output ipr_pkg::ctrl_res_t    res
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] wp_q, rp_q, cp_q;
	logic [AW-1:0] wp_d, rp_d, cp_d;
	logic [AW-1:0] wp_inc, wp_dec, rp_inc;
	logic          mk_valid_q, mk_valid_d;
	logic [AW-1:0] mk_idx_q, mk_idx_d;
	ipr_pkg::entry_t mk_q, mk_d;
	logic          is_push, ovf, commit, have;

	// ring neighbors with explicit wrap
	assign wp_inc = (wp_q == LAST) ? '0 : wp_q + AW'(1);
	assign wp_dec = (wp_q == '0) ? LAST : wp_q - AW'(1);
	assign rp_inc = (rp_q == LAST) ? '0 : rp_q + AW'(1);

	assign is_push = (operation == ipr_pkg::OP_PUSH);
	assign ovf     = is_push && (wp_inc == rp_q);
	assign commit  = is_push && (ev.ev_type == cfg.sync_type) &&
		(ev.ev_code == cfg.report_code);
	assign have    = !is_push && (cp_q != rp_q);

	assign we    = fire && is_push;
	assign waddr = wp_q;
	assign wdata = ev;
	assign raddr = rp_q;

	// result status for this request
	always_comb begin
		res.got_event  = have;
		res.overflowed = ovf;
		res.marker_hit = mk_valid_q && (mk_idx_q == rp_q);
		res.marker     = mk_q;
	end

	// next pointer and marker state
	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		cp_d       = cp_q;
		mk_valid_d = mk_valid_q;
		mk_idx_d   = mk_idx_q;
		mk_d       = mk_q;
		if (is_push) begin
			wp_d = wp_inc;
			// a push over the marker slot replaces the marker
			if (wp_q == mk_idx_q) begin
				mk_valid_d = 1'b0;
			end
			// drop everything unread, marker goes one slot behind the new event
			if (ovf) begin
				rp_d             = wp_dec;
				cp_d             = wp_dec;
				mk_valid_d       = 1'b1;
				mk_idx_d         = wp_dec;
				mk_d.ev_type     = cfg.sync_type;
				mk_d.ev_code     = cfg.dropped_code;
				mk_d.ev_value    = '0;
			end
			if (commit) begin
				cp_d = wp_inc;
			end
		end else if (have) begin
			rp_d = rp_inc;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			cp_q       <= '0;
			mk_valid_q <= 1'b0;
		end else if (fire) begin
			wp_q       <= wp_d;
			rp_q       <= rp_d;
			cp_q       <= cp_d;
			mk_valid_q <= mk_valid_d;
		end
	end

	// marker payload
	always_ff @(posedge clk) begin
		if (fire) begin
			mk_idx_q <= mk_idx_d;
			mk_q     <= mk_d;
		end
	end

endmodule

### rtl/input_event_packet_ring_unit.sv
// input_event_packet_ring_unit: ring of input events readable per committed packet
// path: a request passes the input register, stage two and the result register
// throughput: one push or pop per cycle unless stalled, one write and one read port
// reset: pointers cleared, registers at defaults, store contents left undefined
// depends on ipr_pkg, ipr_req_if, ipr_rsp_if, ipr_cfg_regs, ipr_ctrl, ipr_store

module input_event_packet_ring_unit #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ipr_req_if.sink                        req,
	ipr_rsp_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ipr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ipr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ipr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int AW = $clog2(DEPTH);

	ipr_pkg::cfg_t      cfg;
	logic               en_s1, en_s2, en_out, fire;
	logic               valid_s1, valid_s2, out_valid_q;
	logic               op_s1;
	ipr_pkg::entry_t    ev_s1, rdata, sel;
	ipr_pkg::ctrl_res_t res, res_s2;
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	ipr_pkg::entry_t    wdata;
	logic               have_q, ovf_q;
	ipr_pkg::entry_t    out_q;

	// configuration registers
	ipr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage enables, bubbles collapse
	assign en_out    = !out_valid_q || rsp.ready;
	assign en_s2     = !valid_s2 || en_out;
	assign en_s1     = !valid_s1 || en_s2;
	assign req.ready = en_s1;
	assign fire      = valid_s1 && en_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			op_s1          <= req.operation;
			ev_s1.ev_type  <= req.event_type;
			ev_s1.ev_code  <= req.event_code;
			ev_s1.ev_value <= req.event_value;
		end
	end

	// pointer control
	ipr_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.operation (op_s1),
		.ev        (ev_s1),
		.cfg       (cfg),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.res       (res)
	);

	// event store, read data lines up with stage two
	ipr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (en_s2),
		.raddr (raddr),
		.rdata (rdata)
	);

	// stage two status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2 <= res;
		end
	end

	// pick marker or stored event, zero when nothing is returned
	always_comb begin
		if (!res_s2.got_event) begin
			sel = '0;
		end else if (res_s2.marker_hit) begin
			sel = res_s2.marker;
		end else begin
			sel = rdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			have_q <= res_s2.got_event;
			ovf_q  <= res_s2.overflowed;
			out_q  <= sel;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.got_event  = have_q;
	assign rsp.out_type   = out_q.ev_type;
	assign rsp.out_code   = out_q.ev_code;
	assign rsp.out_value  = out_q.ev_value;
	assign rsp.overflowed = ovf_q;

	// an empty result is all zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.got_event |->
		(rsp.out_type == 16'd0) && (rsp.out_code == 16'd0) && (rsp.out_value == 32'sd0))
		else $error("empty result carries data");

	// a pop never reports an overflow
	a_pop_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.got_event |-> !rsp.overflowed)
		else $error("popped event flagged as overflow");

	// stage two drains into an empty result register
	a_s2_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_valid_q |=> out_valid_q)
		else $error("stage two stuck with empty result register");

	// an accepted request lands in the input register
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request lost");

endmodule

### tb/ipr_checker.sv
`timescale 1ns / 1ps
// ipr_checker: watches the request, result and register ports of the event ring,
// keeps its own copy of the ring and compares every result with its prediction
// depends on ipr_pkg, ipr_req_if and ipr_rsp_if

module ipr_checker #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ipr_req_if                             req,
	ipr_rsp_if                             rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ipr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ipr_pkg::CFG_DATA_W-1:0] pwdata,
	input  logic [ipr_pkg::CFG_DATA_W-1:0] prdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             outstanding
);

	localparam int PTR_W = $clog2(DEPTH);

	// one reply of the ring as it should leave the block
	typedef struct packed {
		logic               got_event;
		logic [15:0]        ev_type;
		logic [15:0]        ev_code;
		logic signed [31:0] ev_value;
		logic               overflowed;
	} reply_t;

	ipr_pkg::entry_t  ring_store [DEPTH];
	logic [PTR_W-1:0] head;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] commit_mark;
	ipr_pkg::cfg_t    cfg;
	reply_t           awaited_replies [$];
	int               mismatches = 0;

	assign fail_count = mismatches;

	function automatic void flag(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] p);
		return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	// apply one push or pop to the ring copy and return the reply it yields
	function automatic reply_t ring_reply(input logic op, input logic [15:0] ev_type,
		input logic [15:0] ev_code, input logic signed [31:0] ev_value);
		reply_t           r;
		logic [PTR_W-1:0] marker_slot;
		r = '0;
		if (op == ipr_pkg::OP_PUSH) begin
			ring_store[head] = '{ev_type, ev_code, ev_value};
			head = slot_after(head);
			// head caught the tail: drop everything unread, leave a marker
			if (head == tail) begin
				marker_slot = PTR_W'((int'(head) + DEPTH - 2) % DEPTH);
				tail = marker_slot;
				ring_store[marker_slot] = '{cfg.sync_type, cfg.dropped_code, 32'sd0};
				commit_mark = marker_slot;
				r.overflowed = 1'b1;
			end
			// a report closes the packet
			if (ev_type == cfg.sync_type && ev_code == cfg.report_code)
				commit_mark = head;
		end else if (commit_mark != tail) begin
			r.got_event = 1'b1;
			r.ev_type = ring_store[tail].ev_type;
			r.ev_code = ring_store[tail].ev_code;
			r.ev_value = ring_store[tail].ev_value;
			tail = slot_after(tail);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t exp;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				ring_store[i] = '0;
			head = '0;
			tail = '0;
			commit_mark = '0;
			cfg = '{ipr_pkg::SYNC_TYPE_RST, ipr_pkg::REPORT_CODE_RST,
				ipr_pkg::DROPPED_CODE_RST};
			awaited_replies.delete();
		end else begin
			// results leaving the block
			if (rsp.valid && rsp.ready) begin
				if (awaited_replies.size() == 0) begin
					flag("result with no request outstanding");
				end else begin
					exp = awaited_replies.pop_front();
					if (rsp.got_event !== exp.got_event || rsp.out_type !== exp.ev_type ||
						rsp.out_code !== exp.ev_code || rsp.out_value !== exp.ev_value ||
						rsp.overflowed !== exp.overflowed)
						flag($sformatf({"expected got=%0b type=%h code=%h value=%0d ovf=%0b,",
							" got got=%0b type=%h code=%h value=%0d ovf=%0b"},
							exp.got_event, exp.ev_type, exp.ev_code, exp.ev_value,
							exp.overflowed, rsp.got_event, rsp.out_type, rsp.out_code,
							rsp.out_value, rsp.overflowed));
				end
			end

			// requests entering the block
			if (req.valid && req.ready)
				awaited_replies.push_back(ring_reply(req.operation, req.event_type,
					req.event_code, req.event_value));

			// register writes and readback
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[ipr_pkg::CFG_ADDR_W-1:2])
						ipr_pkg::REG_SYNC_TYPE:    cfg.sync_type = pwdata[15:0];
						ipr_pkg::REG_REPORT_CODE:  cfg.report_code = pwdata[15:0];
						ipr_pkg::REG_DROPPED_CODE: cfg.dropped_code = pwdata[15:0];
						default:                   ;
					endcase
				end else begin
					case (paddr[ipr_pkg::CFG_ADDR_W-1:2])
						ipr_pkg::REG_SYNC_TYPE:    exp.ev_type = cfg.sync_type;
						ipr_pkg::REG_REPORT_CODE:  exp.ev_type = cfg.report_code;
						ipr_pkg::REG_DROPPED_CODE: exp.ev_type = cfg.dropped_code;
						default:                   exp.ev_type = prdata[15:0];
					endcase
					if (prdata[15:0] !== exp.ev_type)
						flag($sformatf("register at %h: expected %h, got %h",
							paddr, exp.ev_type, prdata[15:0]));
				end
			end
		end
		outstanding <= awaited_replies.size();
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: drives pushes, pops and register writes into input_event_packet_ring_unit
// under random idling and back pressure; ipr_checker predicts and compares the results
// depends on ipr_pkg, ipr_req_if, ipr_rsp_if, ipr_checker and the block itself

module testbench;

	localparam int          DEPTH        = 16;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int          LONG_HOLD    = 120;
	localparam int          PHASE_ITEMS  = 230;
	localparam logic [ipr_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ipr_pkg::CFG_ADDR_W-1:0] paddr;
	logic [ipr_pkg::CFG_DATA_W-1:0] pwdata;
	logic [ipr_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;
	int                             fail_count;
	int                             outstanding;

	// stimulus state
	logic        calm = 1'b0;
	logic        no_idling = 1'b0;
	logic        long_hold_req = 1'b0;
	logic        long_hold_done = 1'b0;
	int          items_sent = 0;
	int unsigned cycles = 0;
	logic [15:0] cur_sync = ipr_pkg::SYNC_TYPE_RST;
	logic [15:0] cur_report = ipr_pkg::REPORT_CODE_RST;

	ipr_req_if req_ch ();
	ipr_rsp_if rsp_ch ();

	always #6 clk = ~clk;

	input_event_packet_ring_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	ipr_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("input_event_packet_ring_unit test failed");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off, none at the end
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req && !long_hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end else if (no_idling || $urandom_range(0, 3) != 0) begin
				rsp_ch.ready <= 1'b1;
				repeat (no_idling ? 1 : $urandom_range(1, 30)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// one register access: setup, then access, then idle with psel low
	task automatic reg_access(input logic write, input logic [ipr_pkg::REG_IDX_W-1:0] idx,
		input logic [ipr_pkg::CFG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [ipr_pkg::CFG_DATA_W-1:0] sync_val,
		input logic [ipr_pkg::CFG_DATA_W-1:0] report_val,
		input logic [ipr_pkg::CFG_DATA_W-1:0] dropped_val);
		reg_access(1'b1, ipr_pkg::REG_SYNC_TYPE, sync_val);
		reg_access(1'b1, ipr_pkg::REG_REPORT_CODE, report_val);
		reg_access(1'b1, ipr_pkg::REG_DROPPED_CODE, dropped_val);
		reg_access(1'b0, ipr_pkg::REG_SYNC_TYPE, '0);
		reg_access(1'b0, ipr_pkg::REG_REPORT_CODE, '0);
		reg_access(1'b0, ipr_pkg::REG_DROPPED_CODE, '0);
		cur_sync = sync_val[15:0];
		cur_report = report_val[15:0];
	endtask

	// offer one request, with an occasional gap before it
	task automatic send_request(input logic op, input logic [15:0] ev_type,
		input logic [15:0] ev_code, input logic [31:0] ev_value);
		if (!no_idling && !calm && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.event_type <= ev_type;
		req_ch.event_code <= ev_code;
		req_ch.event_value <= ev_value;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// let every outstanding result drain before touching registers
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] random_type();
		return ($urandom_range(0, 7) == 0) ? cur_sync : 16'($urandom);
	endfunction

	// mostly whole packets and pops, some floods and some noise
	task automatic random_phase(input int count);
		int target;
		int kind;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				calm = ~calm;
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// packet of events closed by a report
				repeat ($urandom_range(0, 5))
					send_request(ipr_pkg::OP_PUSH, random_type(), 16'($urandom), $urandom);
				send_request(ipr_pkg::OP_PUSH, cur_sync, cur_report, $urandom);
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 8))
					send_request(ipr_pkg::OP_POP, 16'($urandom), 16'($urandom), $urandom);
			end else if (kind < 86) begin
				// flood until unread events get dropped
				repeat ($urandom_range(15, 20))
					send_request(ipr_pkg::OP_PUSH, random_type(), 16'($urandom), $urandom);
				if ($urandom_range(0, 1) == 1)
					send_request(ipr_pkg::OP_PUSH, cur_sync, cur_report, $urandom);
			end else begin
				repeat ($urandom_range(1, 4))
					send_request(($urandom_range(0, 1) == 1) ? ipr_pkg::OP_POP :
						ipr_pkg::OP_PUSH, random_type(), 16'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = ipr_pkg::OP_PUSH;
		req_ch.event_type = '0;
		req_ch.event_code = '0;
		req_ch.event_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, field extremes, open packet, commit, drain
		send_request(ipr_pkg::OP_POP, 16'($urandom), 16'($urandom), $urandom);
		send_request(ipr_pkg::OP_PUSH, 16'hFFFF, 16'h0000, 32'h8000_0000);
		send_request(ipr_pkg::OP_PUSH, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF);
		send_request(ipr_pkg::OP_POP, 16'($urandom), 16'($urandom), $urandom);
		send_request(ipr_pkg::OP_PUSH, cur_sync, cur_report, 32'hFFFF_FFFF);
		repeat (4) send_request(ipr_pkg::OP_POP, 16'($urandom), 16'($urandom), $urandom);

		// directed: wrap the ring, the last push overflows and commits at once
		repeat (15)
			send_request(ipr_pkg::OP_PUSH, 16'($urandom_range(1, 16'hFFFF)), 16'($urandom),
				$urandom);
		send_request(ipr_pkg::OP_PUSH, cur_sync, cur_report, 32'h0);
		repeat (3) send_request(ipr_pkg::OP_POP, 16'($urandom), 16'($urandom), $urandom);

		// all-ones sync and report, zero marker code, plus an unmapped write
		wait_idle();
		configure(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_0000);
		reg_access(1'b1, REG_UNMAPPED, $urandom);
		long_hold_req = 1'b1;
		random_phase(PHASE_ITEMS);

		wait_idle();
		configure(32'h0000_0000, 32'h0000_FFFF, 32'h0000_FFFF);
		random_phase(PHASE_ITEMS);

		wait_idle();
		configure($urandom, $urandom, $urandom);
		random_phase(PHASE_ITEMS);

		// back to defaults, full rate on both sides
		wait_idle();
		no_idling = 1'b1;
		calm = 1'b1;
		configure(ipr_pkg::SYNC_TYPE_RST, ipr_pkg::REPORT_CODE_RST, ipr_pkg::DROPPED_CODE_RST);
		random_phase(PHASE_ITEMS);

		wait_idle();
		if (fail_count == 0)
			$display("input_event_packet_ring_unit test passed");
		else
			$display("input_event_packet_ring_unit test failed");
		$finish;
	end

endmodule
